// File: design/bbed_pkg.sv
// ----------------------------------------------------------------------------
// bbed_pkg
// Shared constants, types and helpers of the bit-packed block element decoder.
// ----------------------------------------------------------------------------
package bbed_pkg;

	localparam int MEM_WORDS  = 256;
	localparam int MEM_AW     = $clog2(MEM_WORDS);
	localparam int MB_SIZE    = 32;
	localparam int MB_COUNT   = 4;
	localparam int ELEM_COUNT = MB_COUNT * MB_SIZE;
	localparam int POS_W      = $clog2(MB_SIZE);
	localparam int MB_W       = (MB_COUNT > 1) ? $clog2(MB_COUNT) : 1;
	localparam int WIDTH_W    = 6;
	localparam int OFS_W      = 8;
	localparam int BIT_W      = WIDTH_W + POS_W;
	localparam int SUM_W      = 10;

	localparam logic [MEM_AW-1:0] HDR_REF_ADDR   = MEM_AW'(0);
	localparam logic [MEM_AW-1:0] HDR_WIDTH_ADDR = MEM_AW'(1);
	localparam int                DATA_BASE      = 2;
	localparam logic [7:0]        WIDTH_MAX      = 8'd32;

	typedef enum logic {
		FUNC_WRITE  = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_DAT
	} state_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [31:0]       wdata;
		logic              re;
		logic [MEM_AW-1:0] raddr_a;
		logic [MEM_AW-1:0] raddr_b;
	} mem_req_t;

	typedef struct packed {
		logic               load;
		logic [31:0]        ref_word;
		logic [WIDTH_W-1:0] width;
		logic [4:0]         bit_pos;
	} unpack_t;

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [7:0] wb);
		return (wb > WIDTH_MAX) ? WIDTH_W'(WIDTH_MAX) : wb[WIDTH_W-1:0];
	endfunction

endpackage

// File: design/bbed_if.sv
// ----------------------------------------------------------------------------
// bbed_if
// Valid/ready channels of the decoder: command words in, result words out.
// ----------------------------------------------------------------------------
interface bbed_cmd_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] word_addr;
	logic [31:0] word_data;
	logic [6:0] element_index;

	modport source (output valid, func, word_addr, word_data, element_index, input ready);
	modport sink   (input valid, func, word_addr, word_data, element_index, output ready);
endinterface

interface bbed_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] decoded_value;

	modport source (output valid, decoded_value, input ready);
	modport sink   (input valid, decoded_value, output ready);
endinterface

// File: design/bbed_mem.sv
// ----------------------------------------------------------------------------
// bbed_mem
// Block word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bbed_mem
	import bbed_pkg::*;
(
	input  logic        clk,
	input  mem_req_t    req,
	output logic [31:0] rd_a,
	output logic [31:0] rd_b
);

	logic [31:0] mem_q [MEM_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_a <= mem_q[req.raddr_a];
			rd_b <= mem_q[req.raddr_b];
		end
	end

endmodule

// File: design/bbed_ctrl.sv
// ----------------------------------------------------------------------------
// bbed_ctrl
// Sequencer: header read, data address generation, data read, result load.
// ----------------------------------------------------------------------------
module bbed_ctrl
	import bbed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bbed_cmd_if.sink    cmd,
	input  logic [31:0] rd_a,
	input  logic [31:0] rd_b,
	input  logic        load_ok,
	output mem_req_t    mem_req,
	output unpack_t     unpack
);

	state_t state_q, state_d;

	logic [6:0]         idx_q;
	logic [31:0]        ref_q;
	logic [WIDTH_W-1:0] width_q;
	logic [4:0]         bit_q;

	logic               accept;
	logic               is_decode;
	logic [MB_W-1:0]    mb;
	logic [POS_W-1:0]   pos;
	logic [OFS_W-1:0]   offset;
	logic [WIDTH_W-1:0] width;
	logic [BIT_W-1:0]   bit_lin;
	logic [SUM_W-1:0]   word_sum;
	logic [MEM_AW-1:0]  word_a;

	assign accept    = cmd.valid & cmd.ready;
	assign is_decode = (cmd.func == FUNC_DECODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd.ready       = 1'b0;
		unpack.load     = 1'b0;
		unpack.ref_word = ref_q;
		unpack.width    = width_q;
		unpack.bit_pos  = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (accept && is_decode) state_d = ST_HDR;
			end
			ST_HDR: begin
				state_d = ST_DAT;
			end
			ST_DAT: begin
				if (load_ok) begin
					cmd.ready   = 1'b1;
					unpack.load = 1'b1;
					state_d     = (accept && is_decode) ? ST_HDR : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// data address from the header words
	always_comb begin
		mb     = idx_q[POS_W +: MB_W];
		pos    = idx_q[POS_W-1:0];
		offset = '0;
		for (int j = 0; j < MB_COUNT; j++) begin
			if (MB_W'(j) < mb) begin
				offset = offset + OFS_W'(clamp_width(rd_b[8*j +: 8]));
			end
		end
		width    = clamp_width(rd_b[8*mb +: 8]);
		bit_lin  = BIT_W'(width) * BIT_W'(pos);
		word_sum = SUM_W'(offset) + SUM_W'(DATA_BASE) + SUM_W'(bit_lin[BIT_W-1:5]);
		word_a   = word_sum[MEM_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && is_decode) begin
			idx_q <= 7'(cmd.element_index % ELEM_COUNT);
		end
		if (state_q == ST_HDR) begin
			ref_q   <= rd_a;
			width_q <= width;
			bit_q   <= bit_lin[4:0];
		end
	end

	always_comb begin
		mem_req.we      = accept && !is_decode && (32'(cmd.word_addr) < MEM_WORDS);
		mem_req.waddr   = MEM_AW'(cmd.word_addr);
		mem_req.wdata   = cmd.word_data;
		mem_req.re      = (accept && is_decode) || (state_q == ST_HDR);
		mem_req.raddr_a = (state_q == ST_HDR) ? word_a : HDR_REF_ADDR;
		mem_req.raddr_b = (state_q == ST_HDR) ? MEM_AW'(word_a + MEM_AW'(1)) : HDR_WIDTH_ADDR;
	end

endmodule

// File: design/bbed_unpack.sv
// ----------------------------------------------------------------------------
// bbed_unpack
// Field extraction from the two-word window, reference add, result register.
// ----------------------------------------------------------------------------
module bbed_unpack
	import bbed_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  unpack_t     unpack,
	input  logic [31:0] rd_a,
	input  logic [31:0] rd_b,
	output logic        load_ok,
	bbed_res_if.source  res
);

	logic               valid_q;
	logic signed [31:0] value_q;
	logic [63:0]        window;
	logic [31:0]        mask;
	logic [31:0]        field;
	logic [31:0]        sum;

	always_comb begin
		window = {rd_b, rd_a} >> unpack.bit_pos;
		mask   = unpack.width[5] ? 32'hFFFF_FFFF
		                         : ((32'd1 << unpack.width[4:0]) - 32'd1);
		field  = window[31:0] & mask;
		sum    = unpack.ref_word + field;
	end

	assign load_ok = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (unpack.load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (unpack.load) begin
			value_q <= $signed(sum);
		end
	end

	assign res.valid         = valid_q;
	assign res.decoded_value = value_q;

endmodule

// File: design/bitpacked_block_element_decoder.sv
// ----------------------------------------------------------------------------
// bitpacked_block_element_decoder
// Frame-of-reference bit-unpacking decoder over a block word memory.
// ----------------------------------------------------------------------------
// Channels: cmd carries command words, res carries result words, both
// valid/ready. A command with func = write stores word_data at word_addr
// and yields no result; one write is taken every cycle while idle.
// A command with func = decode reads the reference and width words
// (word 0 and word 1) on both memory ports in the accept cycle, forms the
// data word address in the next cycle and reads the two-word window, then
// extracts the field and adds the reference. The result register loads
// from the data state once it is free, and res.valid rises with it.
// A decode occupies the two memory read passes, and the next command
// can be taken in the cycle the result loads.
// If res stalls with a result pending, a finished decode holds its window
// and cmd.ready stays low until the result register frees up.
// Reset clears the sequencer and the result valid; memory contents are
// undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module bitpacked_block_element_decoder
	import bbed_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bbed_cmd_if.sink   cmd,
	bbed_res_if.source res
);

	mem_req_t    mem_req;
	unpack_t     unpack;
	logic [31:0] rd_a;
	logic [31:0] rd_b;
	logic        load_ok;

	bbed_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.load_ok (load_ok),
		.mem_req (mem_req),
		.unpack  (unpack)
	);

	bbed_mem u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	bbed_unpack u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.unpack  (unpack),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.load_ok (load_ok),
		.res     (res)
	);

endmodule

// File: design/bbed_checker.sv
// ----------------------------------------------------------------------------
// bbed_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bbed_checker
	import bbed_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_func,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value))
		else $error("result word changed while stalled");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_func == FUNC_DECODE) |=> !in_ready)
		else $error("command taken during header read");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready, 2))
		else $error("result word without a data read pass");

endmodule

bind bitpacked_block_element_decoder bbed_checker u_bbed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.in_func   (cmd.func),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_value (res.decoded_value)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit-packed block element decoder. The block
// memory is first filled completely, so that no decode ever touches an
// unwritten word. A short directed run then covers the reference extremes,
// widths of zero, 32 and above 32, and the first and last element of each
// miniblock. After it come random blocks: a new header, a few data words
// rewritten, then a burst of decodes with stray writes mixed in. A scoreboard
// keeps its own copy of the memory, predicts every decode result at the
// accept of the command, and checks the result words in order. The run goes
// through phases of sender idling and receiver stalling, and one long
// receiver hold-off that backs up the command channel.
// ----------------------------------------------------------------------------
module tb;
	import bbed_pkg::*;

	localparam int          HALF_PERIOD = 6;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam int unsigned DRAIN_CYCLES = 10;

	class decode_scoreboard;
		logic [31:0]        block_mem [MEM_WORDS];
		logic signed [31:0] expected_values [$];
		int unsigned        failures;

		function new();
			failures = 0;
		endfunction

		function int unsigned limit_width(input logic [7:0] wb);
			return (wb > WIDTH_MAX) ? int'(WIDTH_MAX) : int'(wb);
		endfunction

		function logic [31:0] read_word(input int unsigned addr);
			return (addr < MEM_WORDS) ? block_mem[addr] : 32'd0;
		endfunction

		function logic signed [31:0] predict_value(input logic [6:0] index);
			int unsigned idx;
			int unsigned mb;
			int unsigned ofs;
			int unsigned w;
			int unsigned bitpos;
			int unsigned wa;
			logic [31:0] widths;
			logic [63:0] window;
			logic [63:0] mask;
			idx    = index % ELEM_COUNT;
			mb     = idx / MB_SIZE;
			widths = read_word(HDR_WIDTH_ADDR);
			ofs    = 0;
			for (int j = 0; j < mb; j++)
				ofs += limit_width(widths[8*j +: 8]);
			w      = limit_width(widths[8*mb +: 8]);
			bitpos = w * (idx % MB_SIZE);
			wa     = ofs + DATA_BASE + bitpos / 32;
			window = {read_word(wa + 1), read_word(wa)};
			mask   = (w >= 32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 64'd1);
			return read_word(HDR_REF_ADDR) + 32'((window >> (bitpos % 32)) & mask);
		endfunction

		function void note_input(input logic func, input logic [7:0] addr,
				input logic [31:0] data, input logic [6:0] index);
			if (func == FUNC_WRITE) begin
				if (addr < MEM_WORDS)
					block_mem[addr] = data;
			end else begin
				expected_values.push_back(predict_value(index));
			end
		endfunction

		function void check_result(input logic signed [31:0] got);
			logic signed [31:0] want;
			if (expected_values.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result word %0d (0x%08h) with no decode pending", got, got);
				return;
			end
			want = expected_values.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display("decoded_value mismatch: expected 0x%08h, got 0x%08h", want, got);
			end
		endfunction

		function int unsigned pending();
			return expected_values.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bbed_cmd_if cmd_ch ();
	bbed_res_if res_ch ();

	bitpacked_block_element_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	decode_scoreboard sb;
	int unsigned      send_idle_pct;
	int unsigned      recv_stall_pct;
	bit               hold_req;
	bit               hold_done;
	int unsigned      hold_left;
	int unsigned      quiet_cycles;

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.func          = FUNC_WRITE;
		cmd_ch.word_addr     = '0;
		cmd_ch.word_data     = '0;
		cmd_ch.element_index = '0;
		res_ch.ready         = 1'b0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		hold_req             = 1'b0;
		hold_done            = 1'b0;
		hold_left            = 0;
		quiet_cycles         = 0;
		sb                   = new();
	end

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			sb.note_input(cmd_ch.func, cmd_ch.word_addr, cmd_ch.word_data,
				cmd_ch.element_index);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.decoded_value);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold off the result channel once for a long stretch when asked
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_cmd(input func_t f, input logic [7:0] addr,
			input logic [31:0] data, input logic [6:0] index);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.func          <= f;
		cmd_ch.word_addr     <= addr;
		cmd_ch.word_data     <= data;
		cmd_ch.element_index <= index;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_word(input logic [7:0] addr, input logic [31:0] data);
		send_cmd(FUNC_WRITE, addr, data, 7'($urandom));
	endtask

	task automatic decode_elem(input logic [6:0] index);
		send_cmd(FUNC_DECODE, 8'($urandom), $urandom, index);
	endtask

	function automatic logic [7:0] pick_width();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return 8'd0;
		else if (r < 16)
			return 8'd32;
		else if (r < 24)
			return 8'($urandom_range(255, 33));
		return 8'($urandom_range(31, 1));
	endfunction

	task automatic run_blocks(input int unsigned n_items);
		int unsigned sent;
		int unsigned span;
		logic [31:0] widths;
		sent = 0;
		while (sent < n_items) begin
			widths = {pick_width(), pick_width(), pick_width(), pick_width()};
			write_word(HDR_REF_ADDR, $urandom);
			write_word(HDR_WIDTH_ADDR, widths);
			span = DATA_BASE + 2;
			for (int j = 0; j < MB_COUNT; j++)
				span += sb.limit_width(widths[8*j +: 8]);
			repeat ($urandom_range(4)) begin
				write_word(8'($urandom_range(span - 1, DATA_BASE)), $urandom);
				sent++;
			end
			repeat ($urandom_range(24, 4)) begin
				if ($urandom_range(99) < 8)
					write_word(8'($urandom), $urandom);
				else
					decode_elem(7'($urandom_range(ELEM_COUNT - 1)));
				sent++;
			end
			sent += 2;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int a = 0; a < MEM_WORDS; a++)
			write_word(8'(a), $urandom);

		// widths 32, 0, above 32, 255
		write_word(HDR_REF_ADDR, 32'h7FFF_FFFF);
		write_word(HDR_WIDTH_ADDR, {8'd255, 8'd33, 8'd0, 8'd32});
		write_word(8'd2, 32'hFFFF_FFFF);
		write_word(8'd33, 32'h0000_0000);
		decode_elem(7'd0);
		decode_elem(7'd31);
		decode_elem(7'd32);
		decode_elem(7'd63);
		decode_elem(7'd64);
		decode_elem(7'd95);
		decode_elem(7'd127);
		write_word(HDR_REF_ADDR, 32'h8000_0000);
		write_word(HDR_WIDTH_ADDR, {8'd1, 8'd31, 8'd7, 8'd0});
		decode_elem(7'd0);
		decode_elem(7'd31);
		decode_elem(7'd32);
		decode_elem(7'd45);
		decode_elem(7'd64);
		decode_elem(7'd100);
		write_word(HDR_REF_ADDR, 32'hFFFF_FFFF);
		decode_elem(7'd96);
		decode_elem(7'd127);
		write_word(8'd255, 32'h0000_0000);

		hold_req = 1'b1;
		run_blocks(PHASE_ITEMS);

		send_idle_pct  = 79;
		recv_stall_pct = 0;
		run_blocks(PHASE_ITEMS);

		send_idle_pct  = 0;
		recv_stall_pct = 79;
		run_blocks(PHASE_ITEMS);

		send_idle_pct  = 14;
		recv_stall_pct = 14;
		run_blocks(PHASE_ITEMS);

		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
